[rtl/bcms_pkg.sv]
package bcms_pkg;

  localparam int NumCliques = 1024;
  localparam int CidW = 10;
  localparam int SizeW = 11;
  localparam int CntW = 11;
  localparam int CostW = 14;

  localparam logic [2:0] ActSetSize = 3'd0;
  localparam logic [2:0] ActPush = 3'd1;
  localparam logic [2:0] ActBegin = 3'd2;
  localparam logic [2:0] ActNeighbor = 3'd3;
  localparam logic [2:0] ActEnd = 3'd4;

  localparam logic [SizeW-1:0] SizeMax = 11'd2047;

  typedef struct packed {
    logic [2:0] action;
    logic [CidW-1:0] clique_id;
    logic [SizeW-1:0] value;
    logic [15:0] random;
  } req_t;

endpackage

[rtl/best_clique_move_selector.sv]
// channel   | signals                                   | direction
// request   | valid, ready, action, clique_id, value,    | in
//           | random                                    |
// result    | out_valid, out_ready, target_clique,       | out
//           | edit_delta, moved                         |
// config    | psel, penable, pwrite, paddr, pwdata ...   | in
// After reset the back end zeroes the whole size table and takes no request
// meanwhile. Set, push, begin and a neighbor that extends a run are handled in
// the idle state; a neighbor that closes a run also passes the size table read
// and rate states. End passes those too when it closes a run, then isolation
// read and isolation and, unless the degree is zero, pick, the bit-serial
// modulo when two or more cliques tie and the tie table read; after the result
// a moved vertex passes the table update states. A stalled result holds the
// back end; the front queue keeps taking up to two requests.
module best_clique_move_selector
  import bcms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [2:0] action,
  input  logic [CidW-1:0] clique_id,
  input  logic [SizeW-1:0] value,
  input  logic [15:0] random,
  output logic out_valid,
  input  logic out_ready,
  output logic [CidW-1:0] target_clique,
  output logic signed [11:0] edit_delta,
  output logic moved,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [0:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic prefer_isolation;
  logic q_valid, q_ready, back_busy;
  req_t in_req, q_req;

  assign pready = 1'b1;
  assign prdata = {31'd0, prefer_isolation};
  // Hold the isolation preference; only register zero exists.
  always_ff @(posedge clk) begin
    if (rst) prefer_isolation <= 1'b0;
    else if (psel && penable && pwrite && pready && paddr == 1'b0)
      prefer_isolation <= pwdata[0];
  end

  assign in_req = '{action: action, clique_id: clique_id, value: value, random: random};

  bcms_front u_front (
    .clk(clk), .rst(rst), .in_valid(valid), .in_ready(ready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  bcms_back u_back (
    .clk(clk), .rst(rst), .prefer_isolation(prefer_isolation),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .busy(back_busy),
    .out_valid(out_valid), .out_ready(out_ready), .target_clique(target_clique),
    .edit_delta(edit_delta), .moved(moved)
  );

  a_no_out_when_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> back_busy) else $error("result without work");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(target_clique) && $stable(edit_delta)
    && $stable(moved)) else $error("result changed while waiting");

endmodule

[rtl/bcms_front.sv]
module bcms_front
  import bcms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output req_t q_req
);

  // Two-entry queue; drop unknown action codes at the door.
  req_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop, known;

  assign known = in_req.action == ActSetSize || in_req.action == ActPush ||
                 in_req.action == ActBegin || in_req.action == ActNeighbor ||
                 in_req.action == ActEnd;
  assign in_ready = count != 2'd2;
  assign push = in_valid && in_ready && known;
  assign q_valid = count != 2'd0;
  assign q_req = mem[rd_ptr];
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_req;
  end

endmodule

[rtl/bcms_mod.sv]
module bcms_mod
  import bcms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [15:0] dividend,
  input  logic [CntW-1:0] divisor,
  output logic busy,
  output logic [CntW-1:0] remainder
);

  // Restoring remainder, one dividend bit a cycle.
  logic [4:0] bit_cnt;
  logic [15:0] shreg;
  logic [CntW:0] rem;
  logic [CntW:0] trial;

  assign trial = {rem[CntW-1:0], shreg[15]};
  assign remainder = rem[CntW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      bit_cnt <= 5'd16;
    end else if (busy) begin
      bit_cnt <= bit_cnt - 5'd1;
      if (bit_cnt == 5'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem <= '0;
    end else if (busy) begin
      shreg <= {shreg[14:0], 1'b0};
      rem <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
    end
  end

endmodule

[rtl/bcms_back.sv]
module bcms_back
  import bcms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic prefer_isolation,
  input  logic q_valid,
  output logic q_ready,
  input  req_t q_req,
  output logic busy,
  output logic out_valid,
  input  logic out_ready,
  output logic [CidW-1:0] target_clique,
  output logic signed [11:0] edit_delta,
  output logic moved
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_RATE, S_ISO_RD, S_ISO, S_PICK, S_DIV, S_TRD, S_OUT,
    S_MV1, S_MV2, S_MV3
  } state_t;

  state_t state;
  req_t cur;

  logic [SizeW-1:0] size_mem [NumCliques];
  logic [CidW-1:0] stack_mem [NumCliques];
  logic [CidW-1:0] tie_mem [NumCliques];
  logic [SizeW-1:0] size_rd;
  logic [CidW-1:0] stack_rd, tie_rd;

  logic size_we;
  logic [CidW-1:0] size_waddr, size_raddr;
  logic [SizeW-1:0] size_wdata;
  logic stack_we;
  logic [CidW-1:0] stack_waddr, stack_raddr, stack_wdata;
  logic tie_we;
  logic [CidW-1:0] tie_waddr, tie_raddr, tie_wdata;

  logic [CidW-1:0] clr_addr;
  logic [CntW-1:0] stack_cnt, tie_cnt, run_count;
  logic [CidW-1:0] own_clique, run_clique, target;
  logic [SizeW-1:0] own_degree;
  logic signed [CostW-1:0] best_cost, own_cost, cost, from_cost, deg_cost, delta;
  logic own_cost_seen, is_end, to_filled, from_empty;
  logic [SizeW-1:0] from_size;
  logic div_start, div_busy;
  logic [CntW-1:0] div_rem;

  bcms_mod u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(cur.random),
    .divisor(tie_cnt), .busy(div_busy), .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_waddr] <= size_wdata;
    size_rd <= size_mem[size_raddr];
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rd <= stack_mem[stack_raddr];
    if (tie_we) tie_mem[tie_waddr] <= tie_wdata;
    tie_rd <= tie_mem[tie_raddr];
  end

  assign cost = CostW'(size_rd) - ((run_clique == own_clique) ? CostW'(1) : CostW'(0))
              + CostW'(own_degree) - CostW'({run_count, 1'b0});
  assign deg_cost = CostW'(own_degree);
  assign from_cost = own_cost_seen ? own_cost
                   : CostW'(size_rd) - CostW'(1) + CostW'(own_degree);
  assign q_ready = state == S_IDLE;
  assign busy = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign div_start = state == S_PICK && tie_cnt > CntW'(1);
  assign delta = best_cost - own_cost;
  assign to_filled = size_rd == '0;
  assign from_empty = from_size == '0;

  always_comb begin
    if (state == S_IDLE || state == S_RD) size_raddr = run_clique;
    else if (state == S_MV2) size_raddr = target;
    else size_raddr = own_clique;
    stack_raddr = CidW'(stack_cnt - CntW'(1));
    tie_raddr = (tie_cnt > CntW'(1)) ? div_rem[CidW-1:0] : '0;
  end

  // Drive the table write ports from the current state.
  always_comb begin
    size_we = 1'b0;
    size_waddr = own_clique;
    size_wdata = '0;
    stack_we = 1'b0;
    stack_waddr = CidW'(stack_cnt);
    stack_wdata = own_clique;
    tie_we = 1'b0;
    tie_waddr = CidW'(tie_cnt);
    tie_wdata = run_clique;
    case (state)
      S_CLR: begin
        size_we = 1'b1;
        size_waddr = clr_addr;
      end
      S_IDLE: if (q_valid) begin
        if (q_req.action == ActSetSize) begin
          size_we = 1'b1; size_waddr = q_req.clique_id; size_wdata = q_req.value;
        end
        if (q_req.action == ActPush && stack_cnt < CntW'(NumCliques)) begin
          stack_we = 1'b1; stack_wdata = q_req.clique_id;
        end
      end
      S_RATE: begin
        if (tie_cnt == '0 || cost < best_cost) begin
          tie_we = 1'b1; tie_waddr = '0;
        end else if (cost == best_cost && tie_cnt < CntW'(NumCliques)) begin
          tie_we = 1'b1;
        end
      end
      S_ISO: if (own_degree != '0 && stack_cnt != '0) begin
        tie_wdata = stack_rd;
        if (tie_cnt == '0 || deg_cost < best_cost ||
            (deg_cost == best_cost && prefer_isolation)) begin
          tie_we = 1'b1; tie_waddr = '0;
        end else if (deg_cost == best_cost && tie_cnt < CntW'(NumCliques)) begin
          tie_we = 1'b1;
        end
      end
      S_MV2: begin
        size_we = 1'b1;
        size_wdata = (size_rd != '0) ? size_rd - SizeW'(1) : '0;
      end
      S_MV3: begin
        size_we = 1'b1; size_waddr = target;
        size_wdata = (size_rd != SizeMax) ? size_rd + SizeW'(1) : size_rd;
        if (from_empty && !(to_filled && stack_cnt != '0)
            && stack_cnt < CntW'(NumCliques)) begin
          stack_we = 1'b1;
        end else if (from_empty && to_filled && stack_cnt != '0) begin
          stack_we = 1'b1; stack_waddr = CidW'(stack_cnt - CntW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      stack_cnt <= '0; tie_cnt <= '0; run_count <= '0;
      own_clique <= '0; run_clique <= '0; own_degree <= '0;
      best_cost <= '0; own_cost <= '0; own_cost_seen <= 1'b0;
      is_end <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + CidW'(1);
          if (clr_addr == CidW'(NumCliques - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) begin
          cur <= q_req;
          case (q_req.action)
            ActPush: if (stack_cnt < CntW'(NumCliques)) stack_cnt <= stack_cnt + CntW'(1);
            ActBegin: begin
              own_clique <= q_req.clique_id; own_degree <= q_req.value;
              run_clique <= '0; run_count <= '0; tie_cnt <= '0;
              best_cost <= '0; own_cost <= '0; own_cost_seen <= 1'b0;
            end
            ActNeighbor: begin
              is_end <= 1'b0;
              if (run_count != '0 && q_req.clique_id != run_clique) state <= S_RD;
              else begin
                run_clique <= q_req.clique_id;
                if (run_count != SizeMax) run_count <= run_count + CntW'(1);
              end
            end
            ActEnd: begin
              is_end <= 1'b1;
              state <= (run_count != '0) ? S_RD : S_ISO_RD;
            end
            default: ;
          endcase
        end
        S_RD: state <= S_RATE;
        S_RATE: begin
          if (tie_cnt == '0 || cost < best_cost) begin
            best_cost <= cost; tie_cnt <= CntW'(1);
          end else if (cost == best_cost && tie_cnt < CntW'(NumCliques)) begin
            tie_cnt <= tie_cnt + CntW'(1);
          end
          if (run_clique == own_clique) begin
            own_cost <= cost; own_cost_seen <= 1'b1;
          end
          if (is_end) begin
            run_count <= '0; state <= S_ISO_RD;
          end else begin
            run_clique <= cur.clique_id; run_count <= CntW'(1); state <= S_IDLE;
          end
        end
        S_ISO_RD: state <= S_ISO;
        S_ISO: begin
          own_cost <= from_cost;
          if (own_degree == '0) begin
            tie_cnt <= '0; state <= S_OUT;
          end else begin
            if (stack_cnt != '0) begin
              if (tie_cnt == '0 || deg_cost < best_cost ||
                  (deg_cost == best_cost && prefer_isolation)) begin
                best_cost <= deg_cost; tie_cnt <= CntW'(1);
              end else if (deg_cost == best_cost && tie_cnt < CntW'(NumCliques)) begin
                tie_cnt <= tie_cnt + CntW'(1);
              end
            end
            state <= S_PICK;
          end
        end
        S_PICK: state <= (tie_cnt == '0) ? S_OUT : (tie_cnt > CntW'(1)) ? S_DIV : S_TRD;
        S_DIV: if (!div_busy) state <= S_TRD;
        S_TRD: begin
          target <= tie_rd;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= moved ? S_MV1 : S_IDLE;
        S_MV1: state <= S_MV2;
        S_MV2: begin
          from_size <= (size_rd != '0) ? size_rd - SizeW'(1) : '0;
          state <= S_MV3;
        end
        S_MV3: begin
          if (from_empty && !(to_filled && stack_cnt != '0)) begin
            if (stack_cnt < CntW'(NumCliques)) stack_cnt <= stack_cnt + CntW'(1);
          end else if (to_filled && stack_cnt != '0 && !from_empty) begin
            stack_cnt <= stack_cnt - CntW'(1);
          end
          own_clique <= target;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign target_clique = (tie_cnt == '0) ? own_clique : target;
  assign moved = target_clique != own_clique;
  assign edit_delta = (tie_cnt == '0) ? 12'sd0
                    : (delta > CostW'(2047)) ? 12'sd2047
                    : (delta < -CostW'(2047)) ? -12'sd2047 : delta[11:0];

endmodule
